@@ hdl/audio_waveform_peak_binner_assert.svh @@
// Assertion macros for the waveform peak binner.
// Included by the top level; no other dependencies.
`ifndef AUDIO_WAVEFORM_PEAK_BINNER_ASSERT_SVH
`define AUDIO_WAVEFORM_PEAK_BINNER_ASSERT_SVH

`ifndef SYNTHESIS
`define AWPB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in %m");
`define AWPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");
`else
`define AWPB_ASSERT(label, clk, rst_n, prop)
`define AWPB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/awpb_pkg.sv @@
// Shared types and constants for the waveform peak binner.
// No dependencies; used by the interfaces, the root unit and the top level.
package awpb_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SqW     = 2 * LevelW;
  localparam int unsigned ProdW   = 4 * LevelW;
  // level = floor((mag * 2^41)^(1/4)); the shift fills the 64-bit product range
  localparam int unsigned MagShift = ProdW - (SampleW - 1);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [SampleW-1:0]        mag_t;
  typedef logic [LevelW-1:0]         level_t;
  typedef logic [CountW-1:0]         count_t;

  localparam count_t BinSizeReset = 16'd250;
  localparam level_t LevelSat     = 16'hFFFF;

  typedef struct packed {
    logic start;
    mag_t mag;
  } root_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    level_t level;
  } root_rsp_t;

endpackage

@@ hdl/awpb_if.sv @@
// Handshake channels of the waveform peak binner: samples in, levels out,
// and the bin size write port. Depends on awpb_pkg.
interface awpb_in_if;
  logic              valid;
  logic              ready;
  logic              channel;
  awpb_pkg::sample_t sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface awpb_out_if;
  logic             valid;
  logic             ready;
  logic             out_channel;
  awpb_pkg::level_t bin_level;
  awpb_pkg::level_t max_level;

  modport source (output valid, output out_channel, output bin_level, output max_level,
                  input ready);
  modport sink (input valid, input out_channel, input bin_level, input max_level,
                output ready);
endinterface

interface awpb_cfg_if;
  logic             valid;
  logic             ready;
  awpb_pkg::count_t bin_size;

  modport source (output valid, output bin_size, input ready);
  modport sink (input valid, input bin_size, output ready);
endinterface

@@ hdl/awpb_root4.sv @@
// Iterative fourth-root unit: one result bit per R_SQ/R_QUAD pass through one
// shared multiplier (square, then square again, then compare). Uses awpb_pkg.
module awpb_root4 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  awpb_pkg::root_req_t req_i,
  output awpb_pkg::root_rsp_t rsp_o
);
  import awpb_pkg::*;

  typedef enum logic [1:0] {R_IDLE, R_SQ, R_QUAD, R_DONE} rstate_e;

  rstate_e                state_q, state_d;
  logic [SampleW-2:0]     mag_q, mag_d;
  logic                   sat_q, sat_d;
  level_t                 root_q, root_d;
  level_t                 bit_q, bit_d;
  logic [SqW-1:0]         sq_q, sq_d;
  level_t                 trial;
  logic [SqW-1:0]         mul_a;
  logic [ProdW-1:0]       prod;

  assign trial = root_q | bit_q;
  // the one multiplier: squares the trial value, then squares the square
  assign mul_a = (state_q == R_QUAD) ? sq_q : {{(SqW-LevelW){1'b0}}, trial};
  assign prod  = ProdW'(mul_a) * ProdW'(mul_a);

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    sat_d   = sat_q;
    root_d  = root_q;
    bit_d   = bit_q;
    sq_d    = sq_q;
    case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          mag_d   = req_i.mag[SampleW-2:0];
          sat_d   = req_i.mag[SampleW-1];
          root_d  = '0;
          bit_d   = {1'b1, {(LevelW-1){1'b0}}};
          state_d = R_SQ;
        end
      end
      R_SQ: begin
        sq_d    = prod[SqW-1:0];
        state_d = R_QUAD;
      end
      R_QUAD: begin
        if (prod <= {mag_q, {MagShift{1'b0}}}) begin
          root_d = trial;
        end
        bit_d   = bit_q >> 1;
        state_d = bit_q[0] ? R_DONE : R_SQ;
      end
      R_DONE: begin
        state_d = R_IDLE;
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      mag_q   <= '0;
      sat_q   <= 1'b0;
      root_q  <= '0;
      bit_q   <= '0;
      sq_q    <= '0;
    end else begin
      state_q <= state_d;
      mag_q   <= mag_d;
      sat_q   <= sat_d;
      root_q  <= root_d;
      bit_q   <= bit_d;
      sq_q    <= sq_d;
    end
  end

  assign rsp_o.busy  = (state_q != R_IDLE);
  assign rsp_o.done  = (state_q == R_DONE);
  // full-scale negative magnitude saturates
  assign rsp_o.level = sat_q ? LevelSat : root_q;

endmodule

@@ hdl/audio_waveform_peak_binner.sv @@
// Waveform peak binner top level: per-channel bin state, sequencer, output
// register. Depends on awpb_pkg, awpb_if.sv, awpb_root4 and the assert header.
//
//   channel   dir  payload                               handshake
//   sample_i  in   channel, sample                       valid/ready
//   level_o   out  out_channel, bin_level, max_level     valid/ready
//   cfg_i     in   bin_size                              valid/ready, always ready
//
// A sample that does not close a bin passes through transfer and update.
// A sample that closes a bin passes through update, the root (16 bits, each
// through the one multiplier in awpb_root4), done, then emit.
// Reset clears every channel's peak, count and maximum; bin_size becomes 250.
// A result held in the output register stalls the sequencer only when the
// next result is ready before the previous one has been taken.

`include "audio_waveform_peak_binner_assert.svh"

module audio_waveform_peak_binner #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  awpb_in_if.sink    sample_i,
  awpb_out_if.source level_o,
  awpb_cfg_if.sink   cfg_i
);
  import awpb_pkg::*;

  localparam int unsigned ChanW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_ROOT, S_EMIT} state_e;

  state_e            state_q, state_d;
  count_t            bin_size_q, bin_size_d;
  logic              ch_q, ch_d;
  sample_t           sample_q, sample_d;
  level_t            res_level_q, res_level_d;
  mag_t              peak_q  [CHANNELS];
  mag_t              peak_d  [CHANNELS];
  count_t            count_q [CHANNELS];
  count_t            count_d [CHANNELS];
  level_t            max_q   [CHANNELS];
  level_t            max_d   [CHANNELS];
  logic              out_valid_q, out_valid_d;
  logic              out_ch_q, out_ch_d;
  level_t            out_level_q, out_level_d;
  level_t            out_max_q, out_max_d;

  logic [ChanW-1:0]  idx;
  logic              ch_ok;
  mag_t              mag;
  mag_t              new_peak;
  logic [CountW:0]   count_next;
  logic              bin_full;
  root_req_t         root_req;
  root_rsp_t         root_rsp;

  awpb_root4 u_root4 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  assign idx        = ChanW'(ch_q);
  assign ch_ok      = (int'(ch_q) < CHANNELS);
  assign mag        = sample_q[SampleW-1] ? mag_t'(~sample_q + 1'b1) : mag_t'(sample_q);
  assign new_peak   = (mag > peak_q[idx]) ? mag : peak_q[idx];
  assign count_next = {1'b0, count_q[idx]} + 1'b1;
  // a bin size of zero closes the bin on every sample, like a size of one
  assign bin_full   = !(count_next < {1'b0, bin_size_q});

  always_comb begin
    state_d     = state_q;
    bin_size_d  = bin_size_q;
    ch_d        = ch_q;
    sample_d    = sample_q;
    res_level_d = res_level_q;
    peak_d      = peak_q;
    count_d     = count_q;
    max_d       = max_q;
    out_valid_d = out_valid_q;
    out_ch_d    = out_ch_q;
    out_level_d = out_level_q;
    out_max_d   = out_max_q;
    root_req    = '{start: 1'b0, mag: new_peak};

    if (cfg_i.valid) begin
      bin_size_d = cfg_i.bin_size;
    end
    // drop the held result once the sink takes it
    if (out_valid_q && level_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (sample_i.valid) begin
          ch_d     = sample_i.channel;
          sample_d = sample_i.sample;
          state_d  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!ch_ok) begin
          state_d = S_IDLE;
        end else if (!bin_full) begin
          peak_d[idx]  = new_peak;
          count_d[idx] = count_next[CountW-1:0];
          state_d      = S_IDLE;
        end else begin
          peak_d[idx]    = '0;
          count_d[idx]   = '0;
          root_req.start = 1'b1;
          state_d        = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_rsp.done) begin
          res_level_d = root_rsp.level;
          if (root_rsp.level > max_q[idx]) begin
            max_d[idx] = root_rsp.level;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || level_o.ready) begin
          out_valid_d = 1'b1;
          out_ch_d    = ch_q;
          out_level_d = res_level_q;
          out_max_d   = max_q[idx];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bin_size_q  <= BinSizeReset;
      ch_q        <= 1'b0;
      sample_q    <= '0;
      res_level_q <= '0;
      peak_q      <= '{default: '0};
      count_q     <= '{default: '0};
      max_q       <= '{default: '0};
      out_valid_q <= 1'b0;
      out_ch_q    <= 1'b0;
      out_level_q <= '0;
      out_max_q   <= '0;
    end else begin
      state_q     <= state_d;
      bin_size_q  <= bin_size_d;
      ch_q        <= ch_d;
      sample_q    <= sample_d;
      res_level_q <= res_level_d;
      peak_q      <= peak_d;
      count_q     <= count_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
      out_ch_q    <= out_ch_d;
      out_level_q <= out_level_d;
      out_max_q   <= out_max_d;
    end
  end

  assign sample_i.ready    = (state_q == S_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign level_o.valid     = out_valid_q;
  assign level_o.out_channel = out_ch_q;
  assign level_o.bin_level = out_level_q;
  assign level_o.max_level = out_max_q;

  `AWPB_ASSERT(a_max_covers_level, clk_i, rst_ni, level_o.valid |-> (level_o.max_level >= level_o.bin_level))
  `AWPB_ASSERT(a_root_start_idle, clk_i, rst_ni, root_req.start |-> !root_rsp.busy)
  `AWPB_ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, sample_i.valid && sample_i.ready, !sample_i.ready)

endmodule

@@ test/testbench.sv @@
// Testbench for audio_waveform_peak_binner: directed table, then random samples
// over several bin sizes; bin levels checked against a local peak predictor or typed rows.
// Depends on awpb_pkg and the awpb_in_if / awpb_out_if / awpb_cfg_if interfaces.
`timescale 1ns / 100ps

module testbench;
  import awpb_pkg::*;

  localparam int NumChannels   = 2;
  localparam int PhaseCount    = 10;
  localparam int ItemsPerPhase = 175;
  localparam int SettleCycles  = 64;
  localparam int HoldCycles    = 400;
  localparam int StallLimit    = 3000;
  localparam mag_t FullScaleMag = 24'h800000;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_SIZE} row_kind_e;

  typedef struct packed {
    logic   out_channel;
    level_t bin_level;
    level_t max_level;
  } level_rec_t;

  typedef struct packed {
    row_kind_e  kind;
    logic       ch;
    logic [23:0] data;
    logic       typed;
    level_t     exp_bin;
    level_t     exp_max;
  } dir_row_t;

  localparam int DirRows = 27;
  // typed rows: zero peak, full scale either sign, and a zero bin after a saturated one
  localparam dir_row_t DIRECTED [DirRows] = '{
    '{ROW_SAMPLE, 1'b0, 24'h000000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b1, 24'h000000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SIZE,   1'b0, 24'd1,      1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, 24'h000000, 1'b1, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b1, 24'h800000, 1'b1, 16'hFFFF, 16'hFFFF},
    '{ROW_SAMPLE, 1'b0, 24'h7FFFFF, 1'b1, 16'hFFFF, 16'hFFFF},
    '{ROW_SAMPLE, 1'b0, 24'h000001, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b1, 24'h000000, 1'b1, 16'h0000, 16'hFFFF},
    '{ROW_SAMPLE, 1'b1, 24'hFFFFFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, 24'h555555, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b1, 24'hAAAAAA, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SIZE,   1'b0, 24'd0,      1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, 24'h800001, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b1, 24'h001000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_SIZE,   1'b0, 24'd3,      1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, 24'd100,    1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, -24'sd200,  1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b1, 24'd7,      1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, 24'd50,     1'b0, 16'h0000, 16'h0000},
    '{ROW_SIZE,   1'b0, 24'd65535,  1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, 24'd3000,   1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, -24'sd5,    1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, 24'd17,     1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b1, 24'd12,     1'b0, 16'h0000, 16'h0000},
    // lower the size under channel 0's partial count: the next sample on each
    // channel closes its bin
    '{ROW_SIZE,   1'b0, 24'd2,      1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b0, 24'd9,      1'b0, 16'h0000, 16'h0000},
    '{ROW_SAMPLE, 1'b1, -24'sd9,    1'b0, 16'h0000, 16'h0000}
  };

  logic clk = 1'b0;
  logic rst_n;

  awpb_in_if  sample_ch ();
  awpb_out_if level_ch ();
  awpb_cfg_if size_ch ();

  audio_waveform_peak_binner #(
    .CHANNELS(NumChannels)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(sample_ch),
    .level_o (level_ch),
    .cfg_i   (size_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  mag_t   peak_mag [NumChannels];
  int unsigned bin_fill [NumChannels];
  level_t top_level [NumChannels];
  count_t samples_per_bin;

  level_rec_t pending_levels[$];
  int errors;
  int samples_sent;
  int levels_seen;
  int sizes_written;
  int burst_left;
  int hold_asked;
  int idle_cycles;

  function automatic logic predict_bin_close(input logic ch, input sample_t s,
                                             output level_rec_t rec);
    mag_t mag;
    level_t lvl;
    logic [63:0] scaled;
    logic [63:0] trial;
    logic [63:0] sq;
    mag = s[SampleW-1] ? mag_t'(25'h1000000 - {1'b0, s}) : mag_t'(s);
    if (mag > peak_mag[ch]) peak_mag[ch] = mag;
    rec = '0;
    if (bin_fill[ch] + 1 < samples_per_bin) begin
      bin_fill[ch] = bin_fill[ch] + 1;
      return 1'b0;
    end
    lvl = '0;
    if (peak_mag[ch] >= FullScaleMag) begin
      lvl = LevelSat;
    end else begin
      scaled = {40'b0, peak_mag[ch]} << 41;
      // build the fourth root one bit at a time, MSB first
      for (int b = LevelW - 1; b >= 0; b--) begin
        trial = {48'b0, lvl | (level_t'(1) << b)};
        sq = trial * trial;
        if (sq * sq <= scaled) lvl[b] = 1'b1;
      end
    end
    if (lvl > top_level[ch]) top_level[ch] = lvl;
    peak_mag[ch] = '0;
    bin_fill[ch] = 0;
    rec = '{out_channel: ch, bin_level: lvl, max_level: top_level[ch]};
    return 1'b1;
  endfunction

  function automatic sample_t pick_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: s = 24'h800000;
          1: s = 24'h7FFFFF;
          2: s = 24'h000000;
          3: s = 24'hFFFFFF;
          4: s = 24'h000001;
          default: s = 24'h800001;
        endcase
      end
      1, 2, 3: s = sample_t'($urandom);
      default: s = sample_t'($urandom) >>> $urandom_range(0, SampleW - 1);
    endcase
    return s;
  endfunction

  // Offer one sample, with a random burst gap, possibly none, first when the current burst is used up.
  task automatic push_sample(input logic ch, input sample_t s, input logic typed,
                             input level_rec_t typed_rec);
    level_rec_t rec;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    sample_ch.valid   = 1'b1;
    sample_ch.channel = ch;
    sample_ch.sample  = s;
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
    if (predict_bin_close(ch, s, rec)) pending_levels.push_back(typed ? typed_rec : rec);
  endtask

  // Hold off the sender until every expected level has come, then let the block settle.
  task automatic wait_levels_drained();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_bin_size(input count_t size);
    @(negedge clk);
    size_ch.valid    = 1'b1;
    size_ch.bin_size = size;
    do @(posedge clk); while (!size_ch.ready);
    samples_per_bin = size;
    sizes_written++;
    @(negedge clk);
    size_ch.valid = 1'b0;
  endtask

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // receiver: stall pattern changes per window; a requested hold drops ready for a long stretch
  initial begin : level_sink
    int stall_mode;
    int window_left;
    int hold_served;
    int hold_left;
    int phase;
    stall_mode = 0;
    window_left = 0;
    hold_served = 0;
    hold_left = 0;
    phase = 0;
    level_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left = HoldCycles;
      end
      if (window_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        window_left = $urandom_range(16, 96);
      end else begin
        window_left--;
      end
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        level_ch.ready = 1'b0;
      end else begin
        case (stall_mode)
          0: level_ch.ready = 1'b1;
          1: level_ch.ready = 1'($urandom_range(0, 1));
          2: level_ch.ready = (phase % 4 == 0);
          default: level_ch.ready = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : level_check
    level_rec_t want;
    if (rst_n) begin
      if (level_ch.valid && level_ch.ready) begin
        levels_seen++;
        if (pending_levels.size() == 0) begin
          errors++;
          $display("%0t: unexpected level, actual ch %0d bin %0d max %0d", $time,
                   level_ch.out_channel, level_ch.bin_level, level_ch.max_level);
        end else begin
          want = pending_levels.pop_front();
          report_field("out_channel", int'(want.out_channel), int'(level_ch.out_channel));
          report_field("bin_level", int'(want.bin_level), int'(level_ch.bin_level));
          report_field("max_level", int'(want.max_level), int'(level_ch.max_level));
        end
      end
      if ((sample_ch.valid && sample_ch.ready) || (level_ch.valid && level_ch.ready)
          || (size_ch.valid && size_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    count_t phase_size [PhaseCount];
    logic cur_ch;
    level_rec_t typed_rec;
    phase_size = '{16'd1, 16'd2, 16'd5, 16'd0, BinSizeReset, 16'd4, 16'hFFFF, 16'd3,
                   16'd0, 16'd1};
    phase_size[8] = count_t'($urandom_range(6, 40));
    errors = 0;
    samples_sent = 0;
    levels_seen = 0;
    sizes_written = 0;
    burst_left = 0;
    hold_asked = 0;
    idle_cycles = 0;
    cur_ch = 1'b0;
    samples_per_bin = BinSizeReset;
    for (int c = 0; c < NumChannels; c++) begin
      peak_mag[c] = '0;
      bin_fill[c] = 0;
      top_level[c] = '0;
    end
    sample_ch.valid   = 1'b0;
    sample_ch.channel = 1'b0;
    sample_ch.sample  = '0;
    size_ch.valid     = 1'b0;
    size_ch.bin_size  = '0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      if (DIRECTED[i].kind == ROW_SIZE) begin
        wait_levels_drained();
        write_bin_size(count_t'(DIRECTED[i].data));
      end else begin
        typed_rec = '{out_channel: DIRECTED[i].ch, bin_level: DIRECTED[i].exp_bin,
                      max_level: DIRECTED[i].exp_max};
        push_sample(DIRECTED[i].ch, sample_t'(DIRECTED[i].data), DIRECTED[i].typed,
                    typed_rec);
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      wait_levels_drained();
      write_bin_size(phase_size[p]);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // stall the level side hard while samples keep coming
        if ((p == 0 && i == 40) || (p == PhaseCount - 1 && i == 60)) hold_asked++;
        if (p == 2 && i == 90) wait_levels_drained();
        if ($urandom_range(0, 2) == 0) cur_ch = 1'($urandom_range(0, 1));
        push_sample(cur_ch, pick_sample(), 1'b0, '0);
      end
    end

    wait_levels_drained();
    repeat (SettleCycles) @(posedge clk);
    if (pending_levels.size() != 0) begin
      errors += pending_levels.size();
      $display("%0t: %0d expected levels never arrived", $time, pending_levels.size());
    end
    $display("summary: %0d samples sent, %0d bin levels checked, %0d bin size writes",
             samples_sent, levels_seen, sizes_written);
    $display("summary: bin sizes 0, 1 and 65535 covered, with two long level-side holds");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/awpb_pkg.sv
hdl/awpb_if.sv
hdl/awpb_root4.sv
hdl/audio_waveform_peak_binner.sv
test/testbench.sv
